// ===== hdl/first_occurrence_dedup_bitmap_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the first-occurrence dedup bitmap
// Concurrent checks clocked by aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_OCCURRENCE_DEDUP_BITMAP_ASSERT_SVH
`define FIRST_OCCURRENCE_DEDUP_BITMAP_ASSERT_SVH

`ifndef SYNTHESIS

`define FODB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define FODB_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`else

`define FODB_ASSERT(label, prop, msg)

`define FODB_NEVER(label, cond, msg)

`endif

`endif

// ===== hdl/fodb_pkg.sv =====
// ----------------------------------------------------------------------------
// First-occurrence dedup bitmap package
// Field widths, result type and result queue sizing shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package fodb_pkg;

    localparam int ID_IN_W         = 16;
    localparam int OUT_POS_W       = 20;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 24;

    localparam int RES_FIFO_AW     = 3;
    localparam int RES_FIFO_DEPTH  = 1 << RES_FIFO_AW;
    localparam int RES_FIFO_LIMIT  = RES_FIFO_DEPTH - 4;

    typedef struct packed {
        logic [OUT_POS_W-1:0] position;
        logic                 has_position;
        logic                 end_of_column;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/fodb_seen_ram.sv =====
// ----------------------------------------------------------------------------
// Seen-bitmap memory
// One write port and one read port with registered read data; a read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module fodb_seen_ram #(
    parameter int ROW_BITS = 11,
    parameter int ENTRY_W  = 40
) (
    input  wire logic                aclk,
    input  wire logic                rd_en,
    input  wire logic [ROW_BITS-1:0] rd_row,
    output logic      [ENTRY_W-1:0]  rd_data,
    input  wire logic                wr_en,
    input  wire logic [ROW_BITS-1:0] wr_row,
    input  wire logic [ENTRY_W-1:0]  wr_data
);

    logic [ENTRY_W-1:0] mem [2**ROW_BITS];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/fodb_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Takes up to two results per cycle and hands out one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module fodb_result_fifo import fodb_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [1:0]             push_cnt,
    input  wire result_t                push_d0,
    input  wire result_t                push_d1,
    input  wire logic                   pop,
    output result_t                     head_data,
    output logic                        not_empty,
    output logic [RES_FIFO_AW:0]        count
);

    result_t                  fifo_mem [RES_FIFO_DEPTH];
    logic [RES_FIFO_AW-1:0]   head_reg, head_next;
    logic [RES_FIFO_AW-1:0]   tail_reg, tail_next;
    logic [RES_FIFO_AW:0]     count_reg, count_next;
    logic [RES_FIFO_AW-1:0]   tail_plus1;
    logic                     do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign tail_plus1 = RES_FIFO_AW'(tail_reg + 1'b1);

    always_comb begin
        head_next  = do_pop ? RES_FIFO_AW'(head_reg + 1'b1) : head_reg;
        tail_next  = RES_FIFO_AW'(tail_reg + RES_FIFO_AW'(push_cnt));
        count_next = (RES_FIFO_AW + 1)'(count_reg + (RES_FIFO_AW + 1)'(push_cnt)
                     - (RES_FIFO_AW + 1)'(do_pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            fifo_mem[tail_reg] <= push_d0;
        end
        if (push_cnt == 2'd2) begin
            fifo_mem[tail_plus1] <= push_d1;
        end
    end

    assign head_data = fifo_mem[head_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

`default_nettype wire

// ===== hdl/first_occurrence_dedup_bitmap.sv =====
// ----------------------------------------------------------------------------
// First-occurrence dedup bitmap
// Streams a column of vertex ids and reports the position of each id's first
// non-null occurrence, followed by one closing result per column.
// ----------------------------------------------------------------------------
// The block accepts one id per clock cycle while s_tready is high. Each id reads
// its row of the seen-bitmap memory in the cycle the transaction is accepted; a
// new id completes the read-modify-write by writing the row back in the next
// cycle, with a forwarding register covering a repeat of the same row in the
// next transaction. Results pass through the update stage and the result queue
// and leave at one per cycle while m_tready is high; a column's last element
// that also yields a new id produces two results. Each memory row carries a
// column tag, so the bitmap is cleared between columns without a sweep. A
// clearing pass over all 2^(ID_BITS-5) rows (2^(ID_BITS-2) for ID_BITS below 8)
// runs after reset and again after every 2^EPOCH_BITS columns; s_tready stays
// low during the pass and while the column end that starts it is in the update stage.
`default_nettype none

`include "first_occurrence_dedup_bitmap_assert.svh"

module first_occurrence_dedup_bitmap import fodb_pkg::*; #(
    parameter int ID_BITS       = 16,
    parameter int POSITION_BITS = 20,
    parameter int EPOCH_BITS    = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [15:0] vertex_id
    input  wire logic                 s_tuser,   // [0] is_null
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [19:0] position, [23:20] zero
    output logic                      m_tuser,   // [0] has_position
    output logic                      m_tlast
);

    localparam int COL_BITS = (ID_BITS >= 8) ? 5 : 2;
    localparam int ROW_BITS = ID_BITS - COL_BITS;
    localparam int ROW_W    = 1 << COL_BITS;
    localparam int ENTRY_W  = EPOCH_BITS + ROW_W;

    logic                     s_fire;
    logic [ID_BITS-1:0]       in_id;

    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic                     null_seen_reg, null_seen_next;
    logic [POSITION_BITS-1:0] first_null_reg, first_null_next;
    logic                     close_has;
    logic [POSITION_BITS-1:0] close_pos;

    logic                     s1_valid_reg;
    logic [ROW_BITS-1:0]      s1_row_reg;
    logic [COL_BITS-1:0]      s1_col_reg;
    logic                     s1_null_reg;
    logic                     s1_last_reg;
    logic [POSITION_BITS-1:0] s1_pos_reg;
    logic                     s1_close_has_reg;
    logic [POSITION_BITS-1:0] s1_close_pos_reg;

    logic [EPOCH_BITS-1:0]    epoch_reg, epoch_next;
    logic                     clr_active_reg, clr_active_next;
    logic [ROW_BITS-1:0]      clr_row_reg, clr_row_next;

    logic                     fwd_valid_reg;
    logic [ROW_BITS-1:0]      fwd_row_reg;
    logic [ENTRY_W-1:0]       fwd_data_reg;

    logic [ENTRY_W-1:0]       rd_data;
    logic [ENTRY_W-1:0]       merged;
    logic [ROW_W-1:0]         cur_bits;
    logic [ROW_W-1:0]         new_bits;
    logic                     keep;
    logic                     wrap_pending;

    logic                     wr_en;
    logic [ROW_BITS-1:0]      wr_row;
    logic [ENTRY_W-1:0]       wr_data;

    logic [1:0]               push_cnt;
    result_t                  keep_res, close_res, push_d0;
    result_t                  head_data;
    logic                     not_empty;
    logic [RES_FIFO_AW:0]     fifo_count;

    // Accept stage: position counter and null tracking depend on inputs only.
    assign s_fire       = s_tvalid && s_tready;
    assign in_id        = ID_BITS'(s_tdata);
    assign wrap_pending = s1_valid_reg && s1_last_reg && (&epoch_reg);
    assign s_tready     = !clr_active_reg && !wrap_pending &&
                          (fifo_count <= (RES_FIFO_AW + 1)'(RES_FIFO_LIMIT));

    always_comb begin
        close_has       = null_seen_reg || s_tuser;
        close_pos       = null_seen_reg ? first_null_reg : count_reg;
        count_next      = count_reg;
        null_seen_next  = null_seen_reg;
        first_null_next = first_null_reg;
        if (s_fire) begin
            if (s_tlast) begin
                count_next      = '0;
                null_seen_next  = 1'b0;
                first_null_next = '0;
            end else begin
                count_next      = count_reg + POSITION_BITS'(1);
                null_seen_next  = close_has;
                first_null_next = close_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            null_seen_reg  <= 1'b0;
            first_null_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end else begin
            count_reg      <= count_next;
            null_seen_reg  <= null_seen_next;
            first_null_reg <= first_null_next;
            s1_valid_reg   <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_row_reg       <= in_id[ID_BITS-1:COL_BITS];
            s1_col_reg       <= in_id[COL_BITS-1:0];
            s1_null_reg      <= s_tuser;
            s1_last_reg      <= s_tlast;
            s1_pos_reg       <= count_reg;
            s1_close_has_reg <= close_has;
            s1_close_pos_reg <= close_has ? close_pos : '0;
        end
    end

    fodb_seen_ram #(
        .ROW_BITS (ROW_BITS),
        .ENTRY_W  (ENTRY_W)
    ) u_seen_ram (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_row  (in_id[ID_BITS-1:COL_BITS]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_data (wr_data)
    );

    // Update stage: a row is live only if its tag matches the current column.
    always_comb begin
        merged   = (fwd_valid_reg && (fwd_row_reg == s1_row_reg)) ? fwd_data_reg : rd_data;
        cur_bits = (merged[ENTRY_W-1 -: EPOCH_BITS] == epoch_reg) ? merged[ROW_W-1:0] : '0;
        keep     = s1_valid_reg && !s1_null_reg && !cur_bits[s1_col_reg];
        new_bits = cur_bits | (ROW_W'(1) << s1_col_reg);
    end

    always_comb begin
        if (clr_active_reg) begin
            wr_en   = 1'b1;
            wr_row  = clr_row_reg;
            wr_data = {epoch_reg, {ROW_W{1'b0}}};
        end else begin
            wr_en   = keep;
            wr_row  = s1_row_reg;
            wr_data = {epoch_reg, new_bits};
        end
    end

    always_comb begin
        epoch_next      = epoch_reg;
        clr_active_next = clr_active_reg;
        clr_row_next    = clr_row_reg;
        if (clr_active_reg) begin
            clr_row_next = ROW_BITS'(clr_row_reg + 1'b1);
            if (&clr_row_reg) begin
                clr_active_next = 1'b0;
            end
        end else if (s1_valid_reg && s1_last_reg) begin
            epoch_next = EPOCH_BITS'(epoch_reg + 1'b1);
            if (&epoch_reg) begin
                clr_active_next = 1'b1;
                clr_row_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg      <= '0;
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
            fwd_valid_reg  <= 1'b0;
        end else begin
            epoch_reg      <= epoch_next;
            clr_active_reg <= clr_active_next;
            clr_row_reg    <= clr_row_next;
            fwd_valid_reg  <= keep && !clr_active_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (keep) begin
            fwd_row_reg  <= s1_row_reg;
            fwd_data_reg <= {epoch_reg, new_bits};
        end
    end

    always_comb begin
        keep_res.position       = OUT_POS_W'(s1_pos_reg);
        keep_res.has_position   = 1'b1;
        keep_res.end_of_column  = 1'b0;
        close_res.position      = OUT_POS_W'(s1_close_pos_reg);
        close_res.has_position  = s1_close_has_reg;
        close_res.end_of_column = 1'b1;
        push_cnt = 2'(keep) + 2'(s1_valid_reg && s1_last_reg);
        push_d0  = keep ? keep_res : close_res;
    end

    fodb_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_d0   (push_d0),
        .push_d1   (close_res),
        .pop       (m_tready),
        .head_data (head_data),
        .not_empty (not_empty),
        .count     (fifo_count)
    );

    assign m_tvalid = not_empty;
    assign m_tdata  = M_TDATA_W'(head_data.position);
    assign m_tuser  = head_data.has_position;
    assign m_tlast  = head_data.end_of_column;

    `FODB_NEVER(a_no_accept_in_clear, s_fire && clr_active_reg,
                "transaction accepted during clearing pass")
    `FODB_ASSERT(a_fifo_room,
                 s1_valid_reg |-> (fifo_count <= (RES_FIFO_AW + 1)'(RES_FIFO_DEPTH - 2)),
                 "result queue may overflow")
    `FODB_ASSERT(a_repeat_forwarded,
                 keep |=> !(keep && (s1_row_reg == $past(s1_row_reg)) &&
                            (s1_col_reg == $past(s1_col_reg)) && !$past(s1_last_reg)),
                 "repeated id kept twice in one column")

endmodule

`default_nettype wire

// ===== tb/sv/dedup_checker.sv =====
// ----------------------------------------------------------------------------
// Result checker for the first-occurrence dedup bitmap
// Watches both stream channels. Every accepted input transaction updates a
// column model (seen ids, element counter, first null), which queues the
// results it implies. Every accepted output transaction is compared field by
// field with the oldest queued result.
// ----------------------------------------------------------------------------
module dedup_checker import fodb_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 s_tlast,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 m_tuser,
    input  wire logic                 m_tlast,
    output int                        fail_count,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    bit                   seen_ids [1 << ID_IN_W];
    logic [ID_IN_W-1:0]   marked_ids [$];
    logic [OUT_POS_W-1:0] elem_pos;
    bit                   null_found;
    logic [OUT_POS_W-1:0] null_pos;
    result_t              expected_results [$];

    task automatic clear_column();
        foreach (marked_ids[i]) seen_ids[marked_ids[i]] = 1'b0;
        marked_ids.delete();
        elem_pos   = '0;
        null_found = 1'b0;
        null_pos   = '0;
    endtask

    task automatic predict_dedup(input logic [ID_IN_W-1:0] vid, input logic nul,
                                 input logic lst);
        result_t r;
        if (nul) begin
            if (!null_found) begin
                null_found = 1'b1;
                null_pos   = elem_pos;
            end
        end else if (!seen_ids[vid]) begin
            seen_ids[vid] = 1'b1;
            marked_ids.insert(marked_ids.size(), vid);
            r.position      = elem_pos;
            r.has_position  = 1'b1;
            r.end_of_column = 1'b0;
            expected_results.insert(expected_results.size(), r);
        end
        elem_pos = elem_pos + 1'b1;
        if (lst) begin
            r.position      = null_found ? null_pos : '0;
            r.has_position  = null_found;
            r.end_of_column = 1'b1;
            expected_results.insert(expected_results.size(), r);
            clear_column();
        end
    endtask

    task automatic compare_result();
        result_t want;
        if (expected_results.size() == 0) begin
            $error("Result transaction with no expected result pending: position %0d",
                   m_tdata[OUT_POS_W-1:0]);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (m_tdata[OUT_POS_W-1:0] !== want.position) begin
                $error("position mismatch: expected %0d, actual %0d",
                       want.position, m_tdata[OUT_POS_W-1:0]);
                fail_count++;
            end
            if (m_tuser !== want.has_position) begin
                $error("has_position mismatch: expected %0b, actual %0b",
                       want.has_position, m_tuser);
                fail_count++;
            end
            if (m_tlast !== want.end_of_column) begin
                $error("end_of_column mismatch: expected %0b, actual %0b",
                       want.end_of_column, m_tlast);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_column();
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) predict_dedup(s_tdata[ID_IN_W-1:0], s_tuser, s_tlast);
            if (m_tvalid && m_tready) compare_result();
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the first-occurrence dedup bitmap
// Drives directed columns and random columns under several sender and
// receiver idle patterns, while the checker predicts and compares every
// result.
// ----------------------------------------------------------------------------
module tb import fodb_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [15:0] vertex_id
    logic                 s_tuser  = 1'b0; // [0] is_null
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [19:0] position, [23:20] zero
    logic                 m_tuser;         // [0] has_position
    logic                 m_tlast;

    int fail_count;
    int outstanding;
    int idle_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;

    first_occurrence_dedup_bitmap uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    dedup_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic feed_item(input logic [15:0] vid, input logic nul, input logic lst);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vid;
        s_tuser  <= nul;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic feed_random_column();
        int unsigned pick;
        int unsigned len;
        logic [15:0] base;
        logic [15:0] vid;
        logic        nul;
        pick = $urandom_range(0, 99);
        if (pick < 80) len = $urandom_range(1, 3);
        else if (pick < 97) len = $urandom_range(4, 16);
        else len = $urandom_range(17, 50);
        base = 16'($urandom());
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(0, 3) == 0) vid = 16'($urandom());
            else vid = base + 16'($urandom_range(0, 7));
            nul = ($urandom_range(0, 99) < 15);
            feed_item(vid, nul, k == len - 1);
            sent++;
        end
    endtask

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int sender_idle [4];
        int recv_stall [4];
        sender_idle = '{0, 65, 0, 32};
        recv_stall  = '{0, 0, 65, 32};

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Repeats, the maximum id as an ordinary id, and nulls inside a column.
        feed_item(16'h0000, 1'b0, 1'b0);
        feed_item(16'hFFFF, 1'b0, 1'b0);
        feed_item(16'h0000, 1'b0, 1'b0);
        feed_item(16'hFFFF, 1'b1, 1'b0);
        feed_item(16'hFFFF, 1'b0, 1'b0);
        feed_item(16'h0000, 1'b1, 1'b0);
        feed_item(16'h1234, 1'b0, 1'b1);
        // Single new id that is also last: two results from one transaction.
        feed_item(16'h0005, 1'b0, 1'b1);
        // Single null column.
        feed_item(16'h5555, 1'b1, 1'b1);
        // Ids from earlier columns count as new again; closing result is empty.
        feed_item(16'h0000, 1'b0, 1'b0);
        feed_item(16'h0000, 1'b0, 1'b1);
        // Null first, then alternating bit patterns.
        feed_item(16'hAAAA, 1'b1, 1'b0);
        feed_item(16'hAAAA, 1'b0, 1'b0);
        feed_item(16'h5555, 1'b0, 1'b0);
        feed_item(16'hFFFF, 1'b0, 1'b0);
        feed_item(16'h5555, 1'b0, 1'b1);
        // Back-to-back repeats ending on a repeat.
        feed_item(16'h8001, 1'b0, 1'b0);
        feed_item(16'h8001, 1'b0, 1'b0);
        feed_item(16'h8001, 1'b0, 1'b1);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = sender_idle[p];
            stall_pct = recv_stall[p];
            while (sent < (p + 1) * 375) feed_random_column();
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
